FILE: hdl/ppf_pkg.sv
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and defaults for the perfect power finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppf_pkg;

    // Parameter defaults
    localparam int VALUE_WIDTH_DEF  = 17;
    localparam int MAX_BASE_DEF     = 362;
    localparam int MAX_EXPONENT_DEF = 16;

    // Fixed result field widths
    localparam int FOUND_W    = 1;
    localparam int BASE_W     = 9;
    localparam int EXPONENT_W = 5;
    localparam int RESULT_W   = FOUND_W + BASE_W + EXPONENT_W;
    localparam int M_TDATA_W  = ((RESULT_W + 7) / 8) * 8;

    // Compare flags from the datapath to the sequencer
    typedef struct packed {
        logic gt;   // power above value
        logic eq;   // power equals value
    } ppf_cmp_t;

endpackage : ppf_pkg

`default_nettype wire

FILE: hdl/perfect_power_finder_unit.sv
// ----------------------------------------------------------------------------
// perfect_power_finder_unit
// Decides whether a value is X^Y (X >= 2, Y >= 2) and reports the largest X.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                    Payload
//  -------  ---  ---------------------------  --------------------------------
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: value
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: found, base, exponent
//
//  One beat in, one beat out. Bases are walked from MAX_BASE down to 2; each
//  base is squared and then raised one exponent at a time, each power compared,
//  the overshooting one included, all on one shared multiplier. A value below
//  4 overshoots at every square. Values near the top of the range try more
//  exponents. A match ends the search at its base. s_axis_tready is high only
//  while idle. A finished result waits in the output register; the next search
//  may run while it waits and stalls only at its own end. rst_n clears the
//  sequencer and the output valid.
//
`default_nettype none

module perfect_power_finder_unit #(
    parameter int VALUE_WIDTH  = ppf_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_BASE     = ppf_pkg::MAX_BASE_DEF,
    parameter int MAX_EXPONENT = ppf_pkg::MAX_EXPONENT_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                   s_axis_tvalid,
    output      logic                                   s_axis_tready,
    // [VALUE_WIDTH-1:0] value, zero padded to whole bytes
    input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,

    output      logic                                   m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // [0] found, [9:1] base, [14:10] exponent, [15] zero
    output      logic [ppf_pkg::M_TDATA_W-1:0]          m_axis_tdata
);

    // Widths derived from the search range
    localparam int BW  = $clog2(MAX_BASE + 1);
    localparam int EW  = $clog2(MAX_EXPONENT + 1);
    localparam int PW  = (VALUE_WIDTH > BW) ? VALUE_WIDTH : BW;
    localparam int PRW = PW + BW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                  state_reg,  state_next;
    logic [VALUE_WIDTH-1:0]  value_reg,  value_next;
    logic [BW-1:0]           base_reg,   base_next;
    logic [EW-1:0]           exp_reg,    exp_next;
    logic [PRW-1:0]          power_reg,  power_next;
    logic                    found_reg,  found_next;
    logic                    mvalid_reg, mvalid_next;
    logic [ppf_pkg::M_TDATA_W-1:0] mdata_reg, mdata_next;

    logic [PRW-1:0]          product;
    ppf_pkg::ppf_cmp_t       cmp;
    logic                    in_beat;
    logic                    out_free;
    logic                    next_base;

    // Shared multiply / compare unit
    ppf_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .BW          (BW),
        .PW          (PW)
    ) u_datapath (
        .power   (power_reg),
        .base_in (base_reg),
        .value   (value_reg),
        .product (product),
        .cmp     (cmp)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !mvalid_reg || m_axis_tready;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    // Leave the current base: power too large or exponent range used up.
    // exp_reg of one means power holds the bare base, which is never checked.
    assign next_base = (exp_reg != EW'(1)) &&
                       (cmp.gt || (!cmp.eq && exp_reg == EW'(MAX_EXPONENT)));

    always_comb
    begin
        state_next  = state_reg;
        value_next  = value_reg;
        base_next   = base_reg;
        exp_next    = exp_reg;
        power_next  = power_reg;
        found_next  = found_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (mvalid_reg && m_axis_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    value_next = s_axis_tdata[VALUE_WIDTH-1:0];
                    base_next  = BW'(MAX_BASE);
                    power_next = PRW'(MAX_BASE);
                    exp_next   = EW'(1);
                    found_next = 1'b0;
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                if (exp_reg == EW'(1))
                begin
                    // square the base
                    power_next = product;
                    exp_next   = EW'(2);
                end
                else if (next_base)
                begin
                    if (base_reg == BW'(2))
                    begin
                        found_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        base_next  = base_reg - BW'(1);
                        power_next = PRW'(base_reg - BW'(1));
                        exp_next   = EW'(1);
                    end
                end
                else if (cmp.eq)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    power_next = product;
                    exp_next   = exp_reg + EW'(1);
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = '0;
                    if (found_reg)
                    begin
                        mdata_next[0]                         = 1'b1;
                        mdata_next[ppf_pkg::BASE_W:1]         = ppf_pkg::BASE_W'(base_reg);
                        mdata_next[ppf_pkg::RESULT_W-1:
                                   ppf_pkg::BASE_W+1]         = ppf_pkg::EXPONENT_W'(exp_reg);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        base_reg  <= base_next;
        exp_reg   <= exp_next;
        power_reg <= power_next;
        found_reg <= found_next;
        mdata_reg <= mdata_next;
    end

endmodule : perfect_power_finder_unit

`default_nettype wire

FILE: hdl/ppf_datapath.sv
// ----------------------------------------------------------------------------
// ppf_datapath
// Shared multiplier and magnitude compare for the power search.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_datapath #(
    parameter int VALUE_WIDTH = ppf_pkg::VALUE_WIDTH_DEF,
    parameter int BW          = ppf_pkg::BASE_W,
    parameter int PW          = ppf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic [PW+BW-1:0]      power,
    input  wire logic [BW-1:0]         base_in,
    input  wire logic [VALUE_WIDTH-1:0] value,
    output      logic [PW+BW-1:0]      product,
    output      ppf_pkg::ppf_cmp_t     cmp
);

    localparam int PRW = PW + BW;

    logic [PRW-1:0] value_ext;

    // Operand fits in PW bits: power is either the base itself or <= value.
    assign product   = PRW'(power[PW-1:0]) * PRW'(base_in);
    assign value_ext = PRW'(value);

    always_comb
    begin
        cmp.gt = (power > value_ext);
        cmp.eq = (power == value_ext);
    end

endmodule : ppf_datapath

`default_nettype wire
